// ===== rtl/nj_pkg.sv =====
// Shared types, widths and fixed-point helpers for the neighbor joining tree builder.
// No dependencies; used by nj_div and neighbor_joining_tree_builder.
package nj_pkg;

  localparam int DIST_IN_W = 32;  // loaded distance, unsigned Q16.16
  localparam int DIST_W    = 40;  // stored distance, signed
  localparam int RS_W      = 48;  // row sum, signed
  localparam int LEN_W     = 32;  // output branch length, signed
  localparam int NODE_W    = 5;   // output node id
  localparam int TAXA_W    = 6;   // taxa_in_use register
  localparam int QW        = 52;  // working width of the datapath

  localparam logic [TAXA_W-1:0] TAXA_RESET = 6'd32;

  localparam logic EV_JOIN = 1'b0;
  localparam logic EV_ROOT = 1'b1;

  // Divide by two, truncating toward zero.
  function automatic logic signed [QW-1:0] half_q(logic signed [QW-1:0] v);
    logic signed [QW-1:0] t;
    t = v + {{(QW-1){1'b0}}, v[QW-1]};
    return t >>> 1;
  endfunction

  // Saturate to a signed range of w bits.
  function automatic logic signed [QW-1:0] sat_q(logic signed [QW-1:0] v, int w);
    logic signed [QW-1:0] hi;
    logic signed [QW-1:0] lo;
    hi = ({{(QW-1){1'b0}}, 1'b1} << (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

endpackage

// ===== rtl/nj_div.sv =====
// Sequential signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on nj_pkg for the working width.
module nj_div #(
  parameter int VW = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [nj_pkg::QW-1:0]  dividend_i,
  input  logic        [VW-1:0]          divisor_i,
  output logic                          done_o,
  output logic signed [nj_pkg::QW-1:0]  quotient_o
);

  localparam int QW = nj_pkg::QW;
  localparam int NW = $clog2(QW + 1);

  logic          busy_q;
  logic          done_q;
  logic          neg_q;
  logic [NW-1:0] cnt_q;
  logic [VW:0]   rem_q;
  logic [QW-1:0] quo_q;
  logic [VW-1:0] dvs_q;

  logic [VW:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem_q[VW-1:0], quo_q[QW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        neg_q  <= dividend_i[QW-1];
        quo_q  <= dividend_i[QW-1] ? QW'(-dividend_i) : QW'(dividend_i);
        rem_q  <= '0;
        dvs_q  <= divisor_i;
        cnt_q  <= NW'(QW);
      end else if (busy_q) begin
        rem_q <= ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
        quo_q <= {quo_q[QW-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == NW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

// ===== rtl/neighbor_joining_tree_builder.sv =====
// Neighbor joining tree builder: loads a distance matrix, then emits joins and root branches.
// Depends on nj_pkg (widths, helpers) and nj_div (sequential divider).
//
// Use: the input channel carries one matrix entry per beat (row, column, distance,
// final flag). Each entry is stored in the distance memory mirrored across the
// diagonal; diagonal entries and indexes at or above MAX_TAXA are dropped. A beat
// with final_entry set starts the tree run over leaves 0 .. n-1, with n being
// taxa_in_use clamped to 3 .. MAX_TAXA; the input stalls until the run's last
// result has been handed to the output register.
// The run emits one join beat per round (n-3 of them) and then three root beats, the
// last one flagged. After the initial row sums, a round over m clusters does the
// per-cluster row-sum divisions, the pair search (one distance memory read per
// candidate pair), an update of each surviving cluster and one more division.
// Run time is set by the single read port of each memory and the bit-serial divider.
// The output register holds a beat while out_stall_i is high; the sequencer waits.
// Reset clears the sequencer, the output valid and sets taxa_in_use to 32; memory
// contents are not cleared. The config register is written whenever cfg_valid_i is
// high and must only change while the block is idle.
module neighbor_joining_tree_builder #(
  parameter int MAX_TAXA = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Config write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [nj_pkg::TAXA_W-1:0]          cfg_data_i,
  // Matrix entry channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [4:0]                         row_index_i,
  input  logic [4:0]                         column_index_i,
  input  logic [nj_pkg::DIST_IN_W-1:0]       distance_i,
  input  logic                               final_entry_i,
  // Result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               event_kind_o,
  output logic [nj_pkg::NODE_W-1:0]          first_node_o,
  output logic [nj_pkg::NODE_W-1:0]          second_node_o,
  output logic signed [nj_pkg::LEN_W-1:0]    first_length_o,
  output logic signed [nj_pkg::LEN_W-1:0]    second_length_o,
  output logic                               last_result_o
);

  localparam int IW     = $clog2(MAX_TAXA);
  localparam int CW     = $clog2(MAX_TAXA + 1);
  localparam int QW     = nj_pkg::QW;
  localparam int DIST_W = nj_pkg::DIST_W;
  localparam int RS_W   = nj_pkg::RS_W;
  localparam int LEN_W  = nj_pkg::LEN_W;
  localparam int DDEPTH = 1 << (2 * IW);

  typedef enum logic [5:0] {
    S_IDLE, S_INIT_ORD, S_RS_RD, S_RS_ACC, S_ROUND,
    S_LEN_O, S_LEN_R, S_LEN_D, S_LEN_W,
    S_SI, S_SI2, S_SJ, S_SJ2, S_SD,
    S_CMP0, S_CMP_R, S_CMP_W,
    S_J_A, S_J_B, S_J_C, S_J_D, S_J_E,
    S_U_O, S_U_X, S_U_Y, S_U_R, S_U_W,
    S_J_W, S_J_EM,
    S_FIN_O, S_FIN_1, S_FIN_2, S_FIN_3, S_FR, S_FR2, S_FR3, S_FEM
  } state_e;

  function automatic logic [2*IW-1:0] daddr(logic [IW-1:0] a, logic [IW-1:0] b);
    if (a < b) return {a, b};
    return {b, a};
  endfunction

  // Memories
  logic signed [DIST_W-1:0] dist_mem [DDEPTH];
  logic signed [RS_W-1:0]   rsum_mem [MAX_TAXA];
  logic signed [RS_W-1:0]   lens_mem [MAX_TAXA];
  logic        [IW-1:0]     ord_mem  [MAX_TAXA];

  logic signed [DIST_W-1:0] d_rd;
  logic signed [RS_W-1:0]   r_rd;
  logic signed [RS_W-1:0]   l_rd;
  logic        [IW-1:0]     o_rd;

  logic [2*IW-1:0] d_raddr, d_waddr;
  logic [IW-1:0]   r_raddr, r_waddr, o_raddr, o_waddr, l_waddr;
  logic            d_we, r_we, o_we, l_we;
  logic signed [DIST_W-1:0] d_wdata;
  logic signed [RS_W-1:0]   r_wdata, l_wdata;
  logic        [IW-1:0]     o_wdata;

  // Sequencer registers
  state_e state_q;
  logic [nj_pkg::TAXA_W-1:0] taxa_q;
  logic [CW-1:0] cnt_q, pi_q, pj_q, px_q, py_q, wp_q;
  logic [IW-1:0] oi_q, oj_q, x_q, y_q, u_q, o0_q, o1_q, o2_q;
  logic signed [RS_W-1:0]   li_q, lj_q, dx_q, dy_q, acc_q, ra_q;
  logic signed [DIST_W-1:0] dxy_q, dux_q, duy_q;
  logic signed [QW-1:0]     best_q, dxdy_q, rz_q, flen_q;
  logic found_q;

  logic                     out_valid_q;
  logic                     ev_q, last_q;
  logic [nj_pkg::NODE_W-1:0] n1_q, n2_q;
  logic signed [LEN_W-1:0]  l1_q, l2_q;

  // Divider
  logic                 div_start;
  logic signed [QW-1:0] div_dividend;
  logic [CW-1:0]        div_divisor;
  logic                 div_done;
  logic signed [QW-1:0] div_quot;

  nj_div #(.VW(CW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Datapath helpers
  logic [CW-1:0]        n_clamp;
  logic                 in_ok;
  logic                 out_free;
  logic                 out_load;
  logic [IW-1:0]        fa, fb, fc;
  logic signed [QW-1:0] q_val, duz_w, rnew_w, rz_w, j1_w, j2_w;
  logic signed [DIST_W+CW+1:0] prod_w;

  always_comb begin
    if (taxa_q < nj_pkg::TAXA_W'(3)) n_clamp = CW'(3);
    else if (int'(taxa_q) > MAX_TAXA) n_clamp = CW'(MAX_TAXA);
    else n_clamp = CW'(taxa_q);
  end

  assign in_ok = (row_index_i != column_index_i) && (int'(row_index_i) < MAX_TAXA) &&
                 (int'(column_index_i) < MAX_TAXA);
  assign out_free = !out_valid_q || !out_stall_i;
  // Load a new result beat into the output register
  assign out_load = out_free && ((state_q == S_J_EM) || (state_q == S_FEM));

  // Root branch rotation over the last three clusters
  always_comb begin
    case (pi_q[1:0])
      2'd0: begin fa = o0_q; fb = o1_q; fc = o2_q; end
      2'd1: begin fa = o1_q; fb = o2_q; fc = o0_q; end
      default: begin fa = o2_q; fb = o0_q; fc = o1_q; end
    endcase
  end

  assign q_val  = QW'(d_rd) - QW'(li_q) - QW'(lj_q);
  assign duz_w  = nj_pkg::sat_q(nj_pkg::half_q(QW'(dux_q) + QW'(duy_q) - QW'(dxy_q)), DIST_W);
  assign rnew_w = nj_pkg::sat_q(QW'(r_rd) - QW'(dux_q) - QW'(duy_q) + duz_w, RS_W);
  assign prod_w = dxy_q * $signed({1'b0, CW'(cnt_q + CW'(2))});
  assign rz_w   = nj_pkg::half_q(QW'(dx_q) + QW'(dy_q) - QW'(prod_w));
  assign j1_w   = nj_pkg::sat_q(nj_pkg::half_q(QW'(dxy_q) + dxdy_q), LEN_W);
  assign j2_w   = nj_pkg::sat_q(nj_pkg::half_q(QW'(dxy_q) - dxdy_q), LEN_W);

  // Read addresses and divider launch
  always_comb begin
    d_raddr      = '0;
    r_raddr      = '0;
    o_raddr      = '0;
    div_start    = 1'b0;
    div_dividend = QW'(r_rd);
    div_divisor  = CW'(cnt_q - CW'(2));
    case (state_q)
      S_RS_RD: d_raddr = daddr(pi_q[IW-1:0], pj_q[IW-1:0]);
      S_LEN_O: o_raddr = pi_q[IW-1:0];
      S_LEN_R: r_raddr = o_rd;
      S_LEN_D: div_start = 1'b1;
      S_SI:    o_raddr = pi_q[IW-1:0];
      S_SJ:    o_raddr = pj_q[IW-1:0];
      S_SJ2:   d_raddr = daddr(oi_q, o_rd);
      S_CMP_R: o_raddr = pi_q[IW-1:0];
      S_J_A:   r_raddr = x_q;
      S_J_B:   r_raddr = y_q;
      S_J_C:   d_raddr = daddr(x_q, y_q);
      S_J_D: begin
        div_start    = 1'b1;
        div_dividend = QW'(dx_q) - QW'(dy_q);
        div_divisor  = cnt_q;
      end
      S_U_O:   o_raddr = pi_q[IW-1:0];
      S_U_X:   d_raddr = daddr(x_q, o_rd);
      S_U_Y:   d_raddr = daddr(y_q, u_q);
      S_U_R:   r_raddr = u_q;
      S_FIN_O: o_raddr = IW'(0);
      S_FIN_1: o_raddr = IW'(1);
      S_FIN_2: o_raddr = IW'(2);
      S_FR:    r_raddr = fa;
      S_FR2:   d_raddr = daddr(fb, fc);
      default: ;
    endcase
  end

  // Write ports
  always_comb begin
    d_we    = 1'b0;
    d_waddr = daddr(IW'(row_index_i), IW'(column_index_i));
    d_wdata = DIST_W'({1'b0, distance_i});
    r_we    = 1'b0;
    r_waddr = pi_q[IW-1:0];
    r_wdata = acc_q;
    o_we    = 1'b0;
    o_waddr = pi_q[IW-1:0];
    o_wdata = pi_q[IW-1:0];
    l_we    = 1'b0;
    l_waddr = pi_q[IW-1:0];
    l_wdata = div_quot[RS_W-1:0];
    case (state_q)
      S_IDLE:     d_we = in_valid_i && in_ok;
      S_INIT_ORD: o_we = 1'b1;
      S_RS_RD:    r_we = (pj_q == cnt_q);
      S_LEN_W:    l_we = div_done;
      S_CMP_W: begin
        o_we    = (pi_q != py_q);
        o_waddr = wp_q[IW-1:0];
        o_wdata = o_rd;
      end
      S_U_W: begin
        d_we    = 1'b1;
        d_waddr = daddr(x_q, u_q);
        d_wdata = duz_w[DIST_W-1:0];
        r_we    = 1'b1;
        r_waddr = u_q;
        r_wdata = rnew_w[RS_W-1:0];
      end
      S_J_W: begin
        r_we    = 1'b1;
        r_waddr = x_q;
        r_wdata = RS_W'(nj_pkg::sat_q(rz_q, RS_W));
        o_we    = 1'b1;
        o_waddr = cnt_q[IW-1:0];
        o_wdata = x_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (d_we) dist_mem[d_waddr] <= d_wdata;
    d_rd <= dist_mem[d_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (r_we) rsum_mem[r_waddr] <= r_wdata;
    r_rd <= rsum_mem[r_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (o_we) ord_mem[o_waddr] <= o_wdata;
    o_rd <= ord_mem[o_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (l_we) lens_mem[l_waddr] <= l_wdata;
    l_rd <= lens_mem[o_raddr];
  end

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taxa_q <= nj_pkg::TAXA_RESET;
    end else if (cfg_valid_i) begin
      taxa_q <= cfg_data_i;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pi_q        <= '0;
      pj_q        <= '0;
      px_q        <= '0;
      py_q        <= '0;
      wp_q        <= '0;
      oi_q        <= '0;
      oj_q        <= '0;
      x_q         <= '0;
      y_q         <= '0;
      u_q         <= '0;
      o0_q        <= '0;
      o1_q        <= '0;
      o2_q        <= '0;
      li_q        <= '0;
      lj_q        <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      acc_q       <= '0;
      ra_q        <= '0;
      dxy_q       <= '0;
      dux_q       <= '0;
      duy_q       <= '0;
      best_q      <= '0;
      dxdy_q      <= '0;
      rz_q        <= '0;
      flen_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      ev_q        <= nj_pkg::EV_JOIN;
      last_q      <= 1'b0;
      n1_q        <= '0;
      n2_q        <= '0;
      l1_q        <= '0;
      l2_q        <= '0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && final_entry_i) begin
            cnt_q   <= n_clamp;
            pi_q    <= '0;
            state_q <= S_INIT_ORD;
          end
        end
        S_INIT_ORD: begin
          if (pi_q == CW'(cnt_q - 1'b1)) begin
            pi_q    <= '0;
            pj_q    <= '0;
            acc_q   <= '0;
            state_q <= S_RS_RD;
          end else begin
            pi_q <= CW'(pi_q + 1'b1);
          end
        end
        // Initial row sums, one distance memory read per entry; skip the diagonal
        S_RS_RD: begin
          if (pj_q == cnt_q) begin
            pj_q  <= '0;
            acc_q <= '0;
            if (pi_q == CW'(cnt_q - 1'b1)) state_q <= S_ROUND;
            else pi_q <= CW'(pi_q + 1'b1);
          end else if (pj_q == pi_q) begin
            pj_q <= CW'(pj_q + 1'b1);
          end else begin
            state_q <= S_RS_ACC;
          end
        end
        S_RS_ACC: begin
          acc_q   <= RS_W'(nj_pkg::sat_q(QW'(acc_q) + QW'(d_rd), RS_W));
          pj_q    <= CW'(pj_q + 1'b1);
          state_q <= S_RS_RD;
        end
        S_ROUND: begin
          pi_q    <= '0;
          state_q <= (cnt_q > CW'(3)) ? S_LEN_O : S_FIN_O;
        end
        // Per-position row sum over (m-2)
        S_LEN_O: state_q <= S_LEN_R;
        S_LEN_R: state_q <= S_LEN_D;
        S_LEN_D: state_q <= S_LEN_W;
        S_LEN_W: begin
          if (div_done) begin
            if (pi_q == CW'(cnt_q - 1'b1)) begin
              pi_q    <= '0;
              found_q <= 1'b0;
              state_q <= S_SI;
            end else begin
              pi_q    <= CW'(pi_q + 1'b1);
              state_q <= S_LEN_O;
            end
          end
        end
        // Pair search, first minimum wins
        S_SI: state_q <= S_SI2;
        S_SI2: begin
          oi_q    <= o_rd;
          li_q    <= l_rd;
          pj_q    <= CW'(pi_q + 1'b1);
          state_q <= S_SJ;
        end
        S_SJ: state_q <= S_SJ2;
        S_SJ2: begin
          oj_q    <= o_rd;
          lj_q    <= l_rd;
          state_q <= S_SD;
        end
        S_SD: begin
          if (!found_q || q_val < best_q) begin
            best_q  <= q_val;
            found_q <= 1'b1;
            px_q    <= pi_q;
            py_q    <= pj_q;
            x_q     <= oi_q;
            y_q     <= oj_q;
          end
          if (pj_q == CW'(cnt_q - 1'b1)) begin
            if (pi_q == CW'(cnt_q - CW'(2))) begin
              state_q <= S_CMP0;
            end else begin
              pi_q    <= CW'(pi_q + 1'b1);
              state_q <= S_SI;
            end
          end else begin
            pj_q    <= CW'(pj_q + 1'b1);
            state_q <= S_SJ;
          end
        end
        // Drop both picked positions from the list
        S_CMP0: begin
          pi_q    <= CW'(px_q + 1'b1);
          wp_q    <= px_q;
          state_q <= S_CMP_R;
        end
        S_CMP_R: state_q <= (pi_q == cnt_q) ? S_J_A : S_CMP_W;
        S_CMP_W: begin
          if (pi_q != py_q) wp_q <= CW'(wp_q + 1'b1);
          pi_q    <= CW'(pi_q + 1'b1);
          state_q <= S_CMP_R;
        end
        // Join lengths and the new cluster's row sum
        S_J_A: begin
          cnt_q   <= CW'(cnt_q - CW'(2));
          state_q <= S_J_B;
        end
        S_J_B: begin
          dx_q    <= r_rd;
          state_q <= S_J_C;
        end
        S_J_C: begin
          dy_q    <= r_rd;
          state_q <= S_J_D;
        end
        S_J_D: begin
          dxy_q   <= d_rd;
          state_q <= S_J_E;
        end
        S_J_E: begin
          if (div_done) begin
            dxdy_q  <= div_quot;
            rz_q    <= rz_w;
            pi_q    <= '0;
            state_q <= S_U_O;
          end
        end
        // Fold x and y into x for every remaining cluster
        S_U_O: state_q <= (pi_q == cnt_q) ? S_J_W : S_U_X;
        S_U_X: begin
          u_q     <= o_rd;
          state_q <= S_U_Y;
        end
        S_U_Y: begin
          dux_q   <= d_rd;
          state_q <= S_U_R;
        end
        S_U_R: begin
          duy_q   <= d_rd;
          state_q <= S_U_W;
        end
        S_U_W: begin
          pi_q    <= CW'(pi_q + 1'b1);
          state_q <= S_U_O;
        end
        S_J_W: begin
          cnt_q   <= CW'(cnt_q + 1'b1);
          state_q <= S_J_EM;
        end
        S_J_EM: begin
          if (out_free) begin
            ev_q        <= nj_pkg::EV_JOIN;
            n1_q        <= nj_pkg::NODE_W'(x_q);
            n2_q        <= nj_pkg::NODE_W'(y_q);
            l1_q        <= j1_w[LEN_W-1:0];
            l2_q        <= j2_w[LEN_W-1:0];
            last_q      <= 1'b0;
            state_q     <= S_ROUND;
          end
        end
        // Three root branches
        S_FIN_O: state_q <= S_FIN_1;
        S_FIN_1: begin
          o0_q    <= o_rd;
          state_q <= S_FIN_2;
        end
        S_FIN_2: begin
          o1_q    <= o_rd;
          state_q <= S_FIN_3;
        end
        S_FIN_3: begin
          o2_q    <= o_rd;
          pi_q    <= '0;
          state_q <= S_FR;
        end
        S_FR:  state_q <= S_FR2;
        S_FR2: begin
          ra_q    <= r_rd;
          state_q <= S_FR3;
        end
        S_FR3: begin
          flen_q  <= nj_pkg::sat_q(nj_pkg::half_q(QW'(ra_q) - QW'(d_rd)), LEN_W);
          state_q <= S_FEM;
        end
        S_FEM: begin
          if (out_free) begin
            ev_q        <= nj_pkg::EV_ROOT;
            n1_q        <= nj_pkg::NODE_W'(fa);
            n2_q        <= '0;
            l1_q        <= flen_q[LEN_W-1:0];
            l2_q        <= '0;
            last_q      <= (pi_q == CW'(2));
            if (pi_q == CW'(2)) begin
              state_q <= S_IDLE;
            end else begin
              pi_q    <= CW'(pi_q + 1'b1);
              state_q <= S_FR;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = ev_q;
  assign first_node_o    = n1_q;
  assign second_node_o   = n2_q;
  assign first_length_o  = l1_q;
  assign second_length_o = l2_q;
  assign last_result_o   = last_q;

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for neighbor_joining_tree_builder: loads distance matrices, runs tree builds.
// Depends on nj_pkg and the RTL; a scoreboard class predicts joins and root branches.
`timescale 1ns / 100ps

module tb_top;

  localparam int NT = 32;

  // One expected result beat
  typedef struct {
    logic             kind;
    logic [4:0]       n1;
    logic [4:0]       n2;
    logic [31:0]      l1;
    logic [31:0]      l2;
    logic             last;
  } tree_beat_t;

  // Tree predictor and store of expected beats
  class tree_scoreboard;
    longint     dist_mem [NT][NT];
    longint     rsum [NT];
    int         order [NT];
    int         act_cnt;
    int         taxa;
    tree_beat_t pending_q [$];
    int         errors;

    function new();
      for (int i = 0; i < NT; i++) begin
        for (int j = 0; j < NT; j++) dist_mem[i][j] = 0;
        rsum[i] = 0;
      end
      taxa = nj_pkg::TAXA_RESET;
      errors = 0;
    endfunction

    function longint clip(longint v, int w);
      longint hi;
      hi = (longint'(1) <<< (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function void push(logic kind, int a, int b, longint la, longint lb, logic last);
      tree_beat_t e;
      e.kind = kind;
      e.n1 = a[4:0];
      e.n2 = b[4:0];
      e.l1 = 32'(clip(la, nj_pkg::LEN_W));
      e.l2 = 32'(clip(lb, nj_pkg::LEN_W));
      e.last = last;
      pending_q.push_back(e);
    endfunction

    function void drop_pos(int p);
      for (int i = p; i + 1 < act_cnt; i++) order[i] = order[i + 1];
      act_cnt--;
    endfunction

    // Note an accepted matrix entry; a final entry runs the whole tree
    function void note_entry(logic [4:0] r, logic [4:0] c, logic [31:0] d, logic fin);
      int n, m, px, py, x, y, u, a, b, cc;
      longint best, q, m2, dx, dy, dxy, dxdy, rz, dux, duy, duz, s;
      longint lens [NT];
      bit found;
      if (r != c) begin
        dist_mem[r][c] = longint'(d);
        dist_mem[c][r] = longint'(d);
      end
      if (!fin) return;
      n = taxa;
      if (n < 3) n = 3;
      if (n > NT) n = NT;
      for (int i = 0; i < n; i++) order[i] = i;
      act_cnt = n;
      for (int i = 0; i < n; i++) begin
        s = 0;
        for (int j = 0; j < n; j++) s = clip(s + dist_mem[i][j], nj_pkg::RS_W);
        rsum[i] = s;
      end
      while (act_cnt > 3) begin
        m = act_cnt;
        px = 0;
        py = 1;
        best = 0;
        found = 0;
        for (int i = 0; i < m; i++) lens[i] = rsum[order[i]] / longint'(m - 2);
        for (int i = 0; i < m; i++)
          for (int j = i + 1; j < m; j++) begin
            q = dist_mem[order[i]][order[j]] - lens[i] - lens[j];
            if (!found || q < best) begin
              best = q;
              px = i;
              py = j;
              found = 1;
            end
          end
        x = order[px];
        y = order[py];
        drop_pos(py);
        drop_pos(px);
        m2 = act_cnt;
        dx = rsum[x];
        dy = rsum[y];
        dxy = dist_mem[x][y];
        dxdy = (dx - dy) / m2;
        rz = (dx + dy - dxy * (m2 + 2)) / 2;
        for (int k = 0; k < act_cnt; k++) begin
          u = order[k];
          dux = dist_mem[x][u];
          duy = dist_mem[y][u];
          duz = clip((dux + duy - dxy) / 2, nj_pkg::DIST_W);
          if (x != u) begin
            dist_mem[x][u] = duz;
            dist_mem[u][x] = duz;
          end
          rsum[u] = clip(rsum[u] - dux - duy + duz, nj_pkg::RS_W);
        end
        rsum[x] = clip(rz, nj_pkg::RS_W);
        order[act_cnt++] = x;
        push(nj_pkg::EV_JOIN, x, y, (dxy + dxdy) / 2, (dxy - dxdy) / 2, 1'b0);
      end
      for (int k = 0; k < 3; k++) begin
        a = order[k];
        b = order[(k + 1) % 3];
        cc = order[(k + 2) % 3];
        push(nj_pkg::EV_ROOT, a, 0, (rsum[a] - dist_mem[b][cc]) / 2, 0, k == 2);
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    // Compare one accepted result beat with the oldest expectation
    task check(logic kind, logic [4:0] n1, logic [4:0] n2, logic [31:0] l1,
               logic [31:0] l2, logic last);
      tree_beat_t e;
      if (pending_q.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      e = pending_q.pop_front();
      if (kind !== e.kind) report($sformatf("event_kind %0b, want %0b", kind, e.kind));
      if (n1 !== e.n1) report($sformatf("first_node %0d, want %0d", n1, e.n1));
      if (n2 !== e.n2) report($sformatf("second_node %0d, want %0d", n2, e.n2));
      if (l1 !== e.l1) report($sformatf("first_length %h, want %h", l1, e.l1));
      if (l2 !== e.l2) report($sformatf("second_length %h, want %h", l2, e.l2));
      if (last !== e.last) report($sformatf("last_result %0b, want %0b", last, e.last));
    endtask
  endclass

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               cfg_valid_i = 1'b0;
  logic                               cfg_ready_o;
  logic [nj_pkg::TAXA_W-1:0]          cfg_data_i = '0;
  logic                               in_valid_i = 1'b0;
  logic                               in_stall_o;
  logic [4:0]                         row_index_i = '0;
  logic [4:0]                         column_index_i = '0;
  logic [nj_pkg::DIST_IN_W-1:0]       distance_i = '0;
  logic                               final_entry_i = 1'b0;
  logic                               out_valid_o;
  logic                               out_stall_i = 1'b0;
  logic                               event_kind_o;
  logic [nj_pkg::NODE_W-1:0]          first_node_o;
  logic [nj_pkg::NODE_W-1:0]          second_node_o;
  logic signed [nj_pkg::LEN_W-1:0]    first_length_o;
  logic signed [nj_pkg::LEN_W-1:0]    second_length_o;
  logic                               last_result_o;

  tree_scoreboard sb = new();

  int  beats_sent = 0;
  int  tx_idle_pct = 33;
  int  rx_idle_pct = 62;
  int  hold_left = 0;
  bit  hold_req = 0;
  bit  loaded [NT][NT];

  always #6 clk_i = ~clk_i;

  neighbor_joining_tree_builder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .row_index_i     (row_index_i),
    .column_index_i  (column_index_i),
    .distance_i      (distance_i),
    .final_entry_i   (final_entry_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_kind_o    (event_kind_o),
    .first_node_o    (first_node_o),
    .second_node_o   (second_node_o),
    .first_length_o  (first_length_o),
    .second_length_o (second_length_o),
    .last_result_o   (last_result_o)
  );

  // Monitor both channels on pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_entry(row_index_i, column_index_i, distance_i, final_entry_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check(event_kind_o, first_node_o, second_node_o, first_length_o,
               second_length_o, last_result_o);
  end

  // Receiver: random stall, or a long hold-off when asked for one
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = 3000;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Offer one entry beat and hold it until accepted
  task send_entry(int r, int c, logic [31:0] d, bit fin);
    int gap;
    if (beats_sent < 70) begin
      tx_idle_pct = 33;
      rx_idle_pct = 62;
    end else if (beats_sent < 140) begin
      tx_idle_pct = 62;
      rx_idle_pct = 33;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < 8) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    row_index_i <= r[4:0];
    column_index_i <= c[4:0];
    distance_i <= d;
    final_entry_i <= fin;
    in_valid_i <= 1'b1;
    loaded[r[4:0]][c[4:0]] = 1;
    loaded[c[4:0]][r[4:0]] = 1;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
  endtask

  // Let every expected beat arrive, then idle a little
  task drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task write_taxa(int v);
    drain();
    cfg_data_i <= v[nj_pkg::TAXA_W-1:0];
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.taxa = v & 63;
    cfg_valid_i <= 1'b0;
  endtask

  function logic [31:0] pick_dist();
    int sel;
    sel = $urandom_range(7);
    if (sel == 0) return 32'd0;
    if (sel == 1) return 32'hFFFF_FFFF;
    if (sel < 4) return $urandom;
    return $urandom_range(32'h00FF_FFFF, 0);
  endfunction

  // One tree build: noise beats, then every unloaded pair and some reloaded ones, last one final
  task build_tree(int v, int noise, bit ties, bit hold);
    int n, pr [$], pc [$];
    logic [31:0] d;
    write_taxa(v);
    n = (v & 63) < 3 ? 3 : ((v & 63) > NT ? NT : (v & 63));
    repeat (noise)
      send_entry($urandom_range(31), $urandom_range(31), pick_dist(), 1'b0);
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++)
        if (!loaded[i][j] || ($urandom_range(3) == 0)) begin
          pr.push_back(i);
          pc.push_back(j);
        end
    if (pr.size() == 0) begin
      pr.push_back(0);
      pc.push_back(n - 1);
    end
    for (int k = 0; k < pr.size(); k++) begin
      d = ties ? 32'h0001_0000 : pick_dist();
      if (hold && k == pr.size() - 1) hold_req = 1;
      // Swap row and column now and then; storage is symmetric
      if ($urandom_range(1)) send_entry(pc[k], pr[k], d, k == pr.size() - 1);
      else send_entry(pr[k], pc[k], d, k == pr.size() - 1);
    end
    // Keep offering beats while the held-off output blocks the run
    if (hold)
      repeat (4) send_entry($urandom_range(31), $urandom_range(31), pick_dist(), 1'b0);
  endtask

  initial begin
    int phase;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Smallest tree: zero and full-scale distances, swapped and diagonal beats
    write_taxa(3);
    send_entry(0, 1, 32'd0, 1'b0);
    send_entry(2, 0, 32'hFFFF_FFFF, 1'b0);
    send_entry(1, 1, 32'h0000_0005, 1'b0);
    send_entry(1, 2, 32'h0001_0000, 1'b1);
    // Leaf count below range clamps to three
    write_taxa(0);
    send_entry(31, 30, 32'hABCD_1234, 1'b0);
    send_entry(0, 1, 32'h0002_0000, 1'b1);
    // Equal distances on every newly sent pair exercise the first-pair tie rule
    build_tree(5, 0, 1, 0);

    phase = 0;
    while (beats_sent < 210) begin
      build_tree($urandom_range(9) < 7 ? $urandom_range(8, 2) : $urandom_range(14, 9),
                 $urandom_range(6), 0, phase == 1);
      phase++;
    end
    build_tree(1, 0, 0, 0);

    drain();
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/nj_pkg.sv
rtl/nj_div.sv
rtl/neighbor_joining_tree_builder.sv
tb/sv/tb_top.sv
